// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define SWM_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("swm assertion failed");

// Same-cycle implication.
`define SWM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swm assertion failed");

// Next-cycle implication.
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swm assertion failed");

`endif

// ===== design/swm_pkg.sv =====
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EVICT
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_EVICT
    } t_cell_op;

    // Broadcast to every cell of the sorted row.
    typedef struct packed {
        t_cell_op                     op;
        logic signed [SAMPLE_W-1:0]   new_val;
        logic signed [SAMPLE_W-1:0]   old_val;
    } t_cell_ctl;

endpackage

// ===== design/swm_cell.sv =====
module swm_cell
    import swm_pkg::*;
(
    input  logic                       i_clk,
    input  t_cell_ctl                  i_ctl,
    input  logic                       i_live,
    input  logic signed [SAMPLE_W-1:0] i_left_val,
    input  logic                       i_left_le,
    input  logic signed [SAMPLE_W-1:0] i_right_val,
    output logic signed [SAMPLE_W-1:0] o_val,
    output logic                       o_le
);

    logic signed [SAMPLE_W-1:0] r_val;
    logic signed [SAMPLE_W-1:0] n_val;

    // Row is sorted ascending, so o_le is high on a prefix of the live cells.
    assign o_le  = i_live && (r_val <= i_ctl.new_val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (o_le) begin
                    n_val = r_val;
                end else if (i_left_le) begin
                    n_val = i_ctl.new_val;
                end else begin
                    n_val = i_left_val;
                end
            end
            CELL_EVICT: begin
                // Every cell at or above the departing value moves down one;
                // among equal values which copy goes makes no difference.
                if (i_live && (r_val >= i_ctl.old_val)) begin
                    n_val = i_right_val;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== design/swm_ring.sv =====
module swm_ring
    import swm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic signed [SAMPLE_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic signed [SAMPLE_W-1:0] o_rd_data
);

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/sliding_window_median_unit.sv =====
// Channel   Direction  Handshake                          Payload
// sample    in         i_sample_valid / o_sample_ready    i_sample (signed 32)
// median    out        o_median_valid / i_median_ready    o_median (signed 32)
// config    in         i_cfg_we (no wait)                 i_cfg_window_size (7)
//
// A request is the insert pass through the cell row; once the window is full
// it is followed by an eviction state that loads the median and shifts the
// oldest sample out of the row, and waits while the median register is busy.
// The median output register frees the input side: a new request is taken
// while a median waits; only the eviction cycle waits for that register.
// Reset or a config write empties the window; no clearing pass is needed.
`include "assert_macros.svh"

module sliding_window_median_unit
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_window_size,
    input  logic                       i_sample_valid,
    output logic                       o_sample_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_median_valid,
    input  logic                       i_median_ready,
    output logic signed [SAMPLE_W-1:0] o_median
);

    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    t_state                     r_state;
    t_state                     n_state;
    logic [WW-1:0]              r_win;
    logic [AW-1:0]              r_mid;
    logic [WW-1:0]              r_fill;
    logic [AW-1:0]              r_pos;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_median;
    logic                       r_same;
    logic signed [SAMPLE_W-1:0] r_new;

    logic                       accept;
    logic                       out_free;
    logic                       load_out;
    logic                       full_after;
    logic [WW:0]                pos_inc;
    logic [AW-1:0]              ring_next;
    logic signed [SAMPLE_W-1:0] ring_rd;
    logic [31:0]                cfg_ext;
    logic [31:0]                cfg_win;
    t_cell_ctl                  cell_ctl;
    t_cell_op                   cell_op;

    logic signed [SAMPLE_W-1:0] cell_val [MAX_WINDOW];
    logic                       cell_le  [MAX_WINDOW];

    assign accept     = i_sample_valid && o_sample_ready;
    assign out_free   = !r_out_valid || i_median_ready;
    assign full_after = ((WW+1)'(r_fill) + (WW+1)'(1)) == (WW+1)'(r_win);
    assign pos_inc    = (WW+1)'(r_pos) + (WW+1)'(1);
    assign ring_next  = (pos_inc >= (WW+1)'(r_win)) ? '0 : AW'(pos_inc);

    // Window size 0 acts as 1, sizes above the row length clamp to it.
    assign cfg_ext = 32'(i_cfg_window_size);
    assign cfg_win = (cfg_ext == 32'd0) ? 32'd1 :
                     (cfg_ext > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : cfg_ext;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && full_after) begin
                    n_state = ST_EVICT;
                end
            end
            ST_EVICT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_sample_ready = 1'b0;
        load_out       = 1'b0;
        cell_op        = CELL_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                o_sample_ready = 1'b1;
                if (i_sample_valid) begin
                    cell_op = CELL_INSERT;
                end
            end
            ST_EVICT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    cell_op  = CELL_EVICT;
                end
            end
            default: begin
                o_sample_ready = 1'b0;
            end
        endcase
    end

    // With a window of one the departing sample is the one just written.
    always_comb begin
        cell_ctl.op      = cell_op;
        cell_ctl.new_val = i_sample;
        cell_ctl.old_val = r_same ? r_new : ring_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_win       <= WW'(1);
            r_mid       <= '0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_win  <= WW'(cfg_win);
                r_mid  <= AW'((cfg_win - 32'd1) >> 1);
                r_fill <= '0;
                r_pos  <= '0;
            end else if (accept) begin
                r_fill <= r_fill + WW'(1);
                r_pos  <= ring_next;
            end else if (load_out) begin
                r_fill <= r_fill - WW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_median_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_same <= (ring_next == r_pos);
            r_new  <= i_sample;
        end
        if (load_out) begin
            r_median <= cell_val[r_mid];
        end
    end

    swm_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_pos),
        .i_wr_data (i_sample),
        .i_rd_en   (accept),
        .i_rd_addr (ring_next),
        .o_rd_data (ring_rd)
    );

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic signed [SAMPLE_W-1:0] left_val;
        logic                       left_le;
        logic signed [SAMPLE_W-1:0] right_val;
        logic                       live;

        if (g == 0) begin : g_first
            assign left_val = '0;
            assign left_le  = 1'b1;
        end else begin : g_inner
            assign left_val = cell_val[g-1];
            assign left_le  = cell_le[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_last
            assign right_val = cell_val[g];
        end else begin : g_mid
            assign right_val = cell_val[g+1];
        end

        assign live = 32'(g) < 32'(r_fill);

        swm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_live      (live),
            .i_left_val  (left_val),
            .i_left_le   (left_le),
            .i_right_val (right_val),
            .o_val       (cell_val[g]),
            .o_le        (cell_le[g])
        );
    end

    assign o_median_valid = r_out_valid;
    assign o_median       = r_median;

    `SWM_ASSERT_IMPLY(a_idle_not_full, i_clk, i_rst_n, r_state == ST_IDLE, r_fill < r_win)
    `SWM_ASSERT_IMPLY(a_evict_full, i_clk, i_rst_n, r_state == ST_EVICT, r_fill == r_win)
    `SWM_ASSERT_NEXT(a_full_goes_evict, i_clk, i_rst_n, accept && full_after, r_state == ST_EVICT)
    `SWM_ASSERT_ALWAYS(a_out_from_evict, i_clk, i_rst_n, !$rose(o_median_valid) || $past(load_out))

endmodule
